// ===== sv/wsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed sample averager package
// Widths, reset values and operation codes shared by the averager.
// ----------------------------------------------------------------------------
package wsa_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int TIME_BITS   = 32;
  localparam int STEP_BITS   = $clog2(SAMPLE_BITS);

  localparam logic [TIME_BITS-1:0] WINDOW_RESET = TIME_BITS'(1000);

  // Input operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [TIME_BITS-1:0]   time_t;

endpackage

// ===== sv/windowed_sample_averager.sv =====
// ----------------------------------------------------------------------------
// Windowed sample averager
// Sums converter samples over a time window and, when the window closes,
// divides the sum by the sample count with a restoring divider.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_op, in_now_time, in_sample
// out      output     out_valid / out_ready  out_average, out_average_valid,
//                                            out_window_done, out_armed
// cfg      input      cfg_valid / cfg_ready  cfg_window_length
//
// An item that does not close a window passes through EVAL and FIN before its
// result is registered; a closing poll also runs DIV, where the divider
// subtractor produces one quotient bit per cycle.
// rst_n is synchronous; it clears the window state and sets the length to 1000.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled output holds the sequencer in its final state only.
// ----------------------------------------------------------------------------
module windowed_sample_averager import wsa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_op,
  input  time_t   in_now_time,
  input  sample_t in_sample,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t out_average,
  output logic    out_average_valid,
  output logic    out_window_done,
  output logic    out_armed,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  time_t   cfg_window_length
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]           state_r;
  time_t                window_length_r;
  logic                 running_r;
  time_t                window_start_r;
  sum_t                 sum_r;
  count_t               count_r;
  sample_t              last_average_r;
  logic                 have_average_r;
  logic                 done_r;

  logic                 op_r;
  time_t                now_r;
  sample_t              smp_r;

  count_t               rem_r;
  sample_t              quo_r;
  count_t               dsr_r;
  logic                 div_zero_r;
  logic [STEP_BITS-1:0] step_r;

  logic                 out_valid_r;
  sample_t              out_average_r;
  logic                 out_average_valid_r;
  logic                 out_window_done_r;
  logic                 out_armed_r;

  sum_t                 sum_nxt;
  count_t               count_nxt;
  time_t                deadline;
  logic                 closes;
  logic [COUNT_BITS:0]  trial;
  logic [COUNT_BITS:0]  diff;
  logic                 ge;
  count_t               rem_nxt;
  sample_t              quo_nxt;
  logic                 out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // Saturating accumulation; the sum cannot overflow while the count is capped.
  always_comb begin
    if (count_r == '1) begin
      sum_nxt   = sum_r;
      count_nxt = count_r;
    end else begin
      sum_nxt   = sum_r + SUM_BITS'(smp_r);
      count_nxt = count_r + COUNT_BITS'(1);
    end
  end

  assign deadline = window_start_r + window_length_r;
  assign closes   = (deadline <= now_r);

  // One restoring division step. The quotient never exceeds the largest
  // sample, so the top SUM_BITS - SAMPLE_BITS bits preload the remainder.
  assign trial   = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign diff    = trial - {1'b0, dsr_r};
  assign ge      = !diff[COUNT_BITS];
  assign rem_nxt = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  assign quo_nxt = {quo_r[SAMPLE_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      window_length_r <= WINDOW_RESET;
      running_r       <= 1'b0;
      window_start_r  <= '0;
      sum_r           <= '0;
      count_r         <= '0;
      last_average_r  <= '0;
      have_average_r  <= 1'b0;
      done_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_length_r <= cfg_window_length;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          done_r <= 1'b0;
          if (in_valid) begin
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_r <= (op_r == OP_POLL && running_r && closes) ? ST_DIV : ST_FIN;
          if (op_r == OP_START) begin
            if (!running_r) begin
              window_start_r <= now_r;
              running_r      <= 1'b1;
            end
          end else if (running_r) begin
            if (closes) begin
              window_start_r <= now_r;
              running_r      <= 1'b0;
              have_average_r <= 1'b1;
              done_r         <= 1'b1;
              sum_r          <= '0;
              count_r        <= '0;
            end else begin
              sum_r   <= sum_nxt;
              count_r <= count_nxt;
            end
          end
        end
        ST_DIV: begin
          if (step_r == STEP_BITS'(SAMPLE_BITS - 1)) begin
            last_average_r <= div_zero_r ? '0 : quo_nxt;
            state_r        <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: captured item, divider datapath and result.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_op;
      now_r <= in_now_time;
      smp_r <= in_sample;
    end
    if (state_r == ST_EVAL) begin
      rem_r      <= sum_nxt[SUM_BITS-1:SAMPLE_BITS];
      quo_r      <= sum_nxt[SAMPLE_BITS-1:0];
      dsr_r      <= count_nxt;
      div_zero_r <= (count_nxt == '0);
      step_r     <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r + STEP_BITS'(1);
    end
    if (state_r == ST_FIN && out_free) begin
      out_average_r       <= last_average_r;
      out_average_valid_r <= have_average_r;
      out_window_done_r   <= done_r;
      out_armed_r         <= running_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average       = out_average_r;
  assign out_average_valid = out_average_valid_r;
  assign out_window_done   = out_window_done_r;
  assign out_armed         = out_armed_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is still being processed");

  a_done_has_average: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_window_done) |-> (out_average_valid && !out_armed))
    else $error("closed window reported without a valid average or still armed");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !div_zero_r)
    else $error("division started with a zero sample count");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && op_r == OP_POLL && running_r && closes)
      |=> (state_r == ST_DIV && step_r == '0))
    else $error("closing poll did not start the divider");
`endif

endmodule
